>>> rtl/assert_macros.svh
// Assertion helpers for the hot-page group table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HPGT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("hot page table assertion failed");
`define HPGT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hot page table assertion failed");
`else
`define HPGT_ASSERT(lbl, clk, rstn, prop)
`define HPGT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/hpgt_pkg.sv
package hpgt_pkg;

    localparam int PPG    = 8;
    localparam int GS     = 16;
    localparam int SLOTS  = PPG * GS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PG_W   = (PPG > 1) ? $clog2(PPG) : 1;
    localparam int GRP_W  = 4;
    localparam int FILL_W = PG_W + 1;
    localparam int OPEN_W = GRP_W + 1;
    localparam int ADDR_W = 48;
    localparam int CNT_W  = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
    localparam logic [OP_W-1:0] OP_BUMP   = 3'd4;

    localparam logic [ST_W-1:0] ST_HIT      = 3'd0;
    localparam logic [ST_W-1:0] ST_ADD_OPEN = 3'd1;
    localparam logic [ST_W-1:0] ST_ADD_NEW  = 3'd2;
    localparam logic [ST_W-1:0] ST_REPLACED = 3'd3;
    localparam logic [ST_W-1:0] ST_REMOVED  = 3'd4;
    localparam logic [ST_W-1:0] ST_ABSENT   = 3'd5;
    localparam logic [ST_W-1:0] ST_PRESENT  = 3'd6;
    localparam logic [ST_W-1:0] ST_BUMPED   = 3'd7;

    typedef struct packed {
        logic load;
        logic scan;
        logic found;
        logic place;
        logic min_step;
        logic ev_rd;
        logic ev_cap;
        logic sh_rd;
        logic sh_wr;
        logic sh_end;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic              hit;
        logic              scan_end;
        logic              is_remove;
        logic              need_min;
        logic              min_more;
        logic              shift_more;
        logic              out_free;
        logic [OPEN_W-1:0] groups_open;
    } t_stat;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

>>> rtl/hpgt_ctrl.sv
module hpgt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hpgt_pkg::t_stat i_stat,
    output hpgt_pkg::t_cmd  o_cmd,
    output logic            o_ready
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SCAN   = 10'b0000000010,
        S_FOUND  = 10'b0000000100,
        S_PLACE  = 10'b0000001000,
        S_MIN    = 10'b0000010000,
        S_EV_RD  = 10'b0000100000,
        S_EV_CAP = 10'b0001000000,
        S_SH_RD  = 10'b0010000000,
        S_SH_WR  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_FOUND;
                end else if (i_stat.scan_end) begin
                    n_state = S_PLACE;
                end
            end
            S_FOUND: begin
                o_cmd.found = 1'b1;
                n_state     = i_stat.is_remove ? S_SH_RD : S_DONE;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = i_stat.need_min ? S_MIN : S_DONE;
            end
            S_MIN: begin
                if (i_stat.min_more) begin
                    o_cmd.min_step = 1'b1;
                end else begin
                    n_state = S_EV_RD;
                end
            end
            S_EV_RD: begin
                o_cmd.ev_rd = 1'b1;
                n_state     = S_EV_CAP;
            end
            S_EV_CAP: begin
                o_cmd.ev_cap = 1'b1;
                n_state      = S_SH_RD;
            end
            S_SH_RD: begin
                if (i_stat.shift_more) begin
                    o_cmd.sh_rd = 1'b1;
                    n_state     = S_SH_WR;
                end else begin
                    o_cmd.sh_end = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_SH_WR: begin
                o_cmd.sh_wr = 1'b1;
                n_state     = S_SH_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

>>> rtl/hpgt_dp.sv
module hpgt_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hpgt_pkg::t_cmd               i_cmd,
    output hpgt_pkg::t_stat              o_stat,
    input  logic                         i_cfg_we,
    input  logic [hpgt_pkg::OPEN_W-1:0]  i_cfg_wdata,
    input  logic [hpgt_pkg::OP_W-1:0]    i_op,
    input  logic [hpgt_pkg::ADDR_W-1:0]  i_addr,
    input  logic [hpgt_pkg::CNT_W-1:0]   i_init,
    input  logic [hpgt_pkg::GRP_W-1:0]   i_sel,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [hpgt_pkg::ST_W-1:0]    o_status,
    output logic [hpgt_pkg::GRP_W-1:0]   o_group_index,
    output logic [hpgt_pkg::CNT_W-1:0]   o_page_count,
    output logic                         o_evicted_valid,
    output logic [hpgt_pkg::ADDR_W-1:0]  o_evicted_address
);

    localparam int SLOT_W = hpgt_pkg::SLOT_W;
    localparam int PG_W   = hpgt_pkg::PG_W;
    localparam int GRP_W  = hpgt_pkg::GRP_W;
    localparam int FILL_W = hpgt_pkg::FILL_W;
    localparam int OPEN_W = hpgt_pkg::OPEN_W;
    localparam int ADDR_W = hpgt_pkg::ADDR_W;
    localparam int CNT_W  = hpgt_pkg::CNT_W;
    localparam int GS     = hpgt_pkg::GS;
    localparam int PPG    = hpgt_pkg::PPG;
    localparam int SLOTS  = hpgt_pkg::SLOTS;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [GRP_W-1:0] g,
                                                  input logic [PG_W-1:0] s);
        return SLOT_W'(int'(g) * PPG + int'(s));
    endfunction

    // slot memory
    logic [ADDR_W-1:0] r_mem_addr [SLOTS];
    logic [CNT_W-1:0]  r_mem_cnt  [SLOTS];
    logic [ADDR_W-1:0] r_rd_addr;
    logic [CNT_W-1:0]  r_rd_cnt;

    // group state
    logic [FILL_W-1:0] r_fill [GS];
    logic [CNT_W-1:0]  r_gcnt [GS];
    logic [OPEN_W-1:0] r_open;
    logic [OPEN_W-1:0] r_maxg;

    // item under work
    logic [hpgt_pkg::OP_W-1:0] r_op;
    logic [ADDR_W-1:0]         r_addr;
    logic [CNT_W-1:0]          r_init;
    logic [GRP_W-1:0]          r_sel;
    logic [SLOT_W:0]           r_idx;
    logic                      r_pend;
    logic [SLOT_W-1:0]         r_pidx;
    logic [SLOT_W-1:0]         r_hidx;
    logic [CNT_W-1:0]          r_hcnt;
    logic [GRP_W-1:0]          r_g;
    logic [PG_W-1:0]           r_k;
    logic [OPEN_W-1:0]         r_mk;
    logic [GRP_W-1:0]          r_min_g;
    logic [CNT_W-1:0]          r_minv;

    // result being built and the output register
    logic [hpgt_pkg::ST_W-1:0] r_st;
    logic [GRP_W-1:0]          r_gi;
    logic [CNT_W-1:0]          r_pc;
    logic                      r_ev;
    logic [ADDR_W-1:0]         r_ea;
    logic                      r_ovalid;
    logic [hpgt_pkg::ST_W-1:0] r_o_st;
    logic [GRP_W-1:0]          r_o_gi;
    logic [CNT_W-1:0]          r_o_pc;
    logic                      r_o_ev;
    logic [ADDR_W-1:0]         r_o_ea;

    logic [GRP_W-1:0]  scan_g;
    logic [PG_W-1:0]   scan_s;
    logic              scan_valid;
    logic              match;
    logic [GRP_W-1:0]  fidx;
    logic [FILL_W-1:0] fill_rd;
    logic [GRP_W-1:0]  cidx;
    logic [CNT_W-1:0]  cnt_rd;
    logic              room_ok;
    logic [GRP_W-1:0]  g_room;
    logic [OPEN_W-1:0] lim;
    logic              can_open;
    logic              is_ins;
    logic              shift_more;
    logic              we;
    logic [SLOT_W-1:0] wa;
    logic [ADDR_W-1:0] wd_a;
    logic [CNT_W-1:0]  wd_c;
    logic              re;
    logic [SLOT_W-1:0] ra;
    logic [CNT_W-1:0]  hit_inc;
    logic [CNT_W-1:0]  bump_inc;

    assign scan_g = GRP_W'(r_idx[SLOT_W-1:0] / PPG);
    assign scan_s = PG_W'(r_idx[SLOT_W-1:0] % PPG);

    // one read place on each group array, steered by the current step
    assign fidx    = i_cmd.scan ? scan_g : (i_cmd.place ? g_room : r_g);
    assign fill_rd = r_fill[fidx];
    assign cidx    = i_cmd.min_step ? r_mk[GRP_W-1:0] : r_sel;
    assign cnt_rd  = r_gcnt[cidx];

    assign scan_valid = (r_idx < (SLOT_W+1)'(SLOTS)) && (OPEN_W'(scan_g) < r_open)
                        && (FILL_W'(scan_s) < fill_rd);
    assign match      = r_pend && (r_rd_addr == r_addr) && (r_op <= hpgt_pkg::OP_LOOKUP);

    assign is_ins     = (r_op == hpgt_pkg::OP_INSERT);
    assign lim        = (r_maxg == '0) ? OPEN_W'(1) :
                        ((r_maxg > OPEN_W'(GS)) ? OPEN_W'(GS) : r_maxg);
    assign can_open   = r_open < lim;
    assign shift_more = (FILL_W'(r_k) + FILL_W'(1)) < fill_rd;
    assign hit_inc    = hpgt_pkg::sat_inc(r_hcnt);
    assign bump_inc   = hpgt_pkg::sat_inc(cnt_rd);

    // first open group with room
    always_comb begin
        room_ok = 1'b0;
        g_room  = '0;
        for (int g = GS - 1; g >= 0; g--) begin
            if ((OPEN_W'(g) < r_open) && (r_fill[g] < FILL_W'(PPG))) begin
                room_ok = 1'b1;
                g_room  = GRP_W'(g);
            end
        end
    end

    always_comb begin
        we   = 1'b0;
        wa   = '0;
        wd_a = r_addr;
        wd_c = r_init;
        if (i_cmd.found && (r_op == hpgt_pkg::OP_INSERT || r_op == hpgt_pkg::OP_UPDATE)) begin
            we   = 1'b1;
            wa   = r_hidx;
            wd_c = hit_inc;
        end else if (i_cmd.place && is_ins && room_ok) begin
            we = 1'b1;
            wa = slot_of(g_room, PG_W'(fill_rd));
        end else if (i_cmd.place && is_ins && can_open) begin
            we = 1'b1;
            wa = slot_of(r_open[GRP_W-1:0], '0);
        end else if (i_cmd.sh_wr) begin
            we   = 1'b1;
            wa   = slot_of(r_g, r_k);
            wd_a = r_rd_addr;
            wd_c = r_rd_cnt;
        end else if (i_cmd.sh_end && !(r_op == hpgt_pkg::OP_REMOVE)) begin
            we = 1'b1;
            wa = slot_of(r_g, PG_W'(fill_rd - FILL_W'(1)));
        end
    end

    always_comb begin
        re = 1'b0;
        ra = '0;
        if (i_cmd.scan && scan_valid) begin
            re = 1'b1;
            ra = r_idx[SLOT_W-1:0];
        end else if (i_cmd.sh_rd) begin
            re = 1'b1;
            ra = slot_of(r_g, PG_W'(r_k + 1'b1));
        end else if (i_cmd.ev_rd) begin
            re = 1'b1;
            ra = slot_of(r_min_g, '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_addr[wa] <= wd_a;
            r_mem_cnt[wa]  <= wd_c;
        end
        if (re) begin
            r_rd_addr <= r_mem_addr[ra];
            r_rd_cnt  <= r_mem_cnt[ra];
        end
    end

    // group state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < GS; g++) begin
                r_fill[g] <= '0;
                r_gcnt[g] <= '0;
            end
            r_open <= '0;
            r_maxg <= OPEN_W'(GS);
        end else begin
            if (i_cfg_we) begin
                r_maxg <= i_cfg_wdata;
            end
            if (i_cmd.place && is_ins) begin
                if (room_ok) begin
                    r_fill[g_room] <= fill_rd + FILL_W'(1);
                end else if (can_open) begin
                    r_fill[r_open[GRP_W-1:0]] <= FILL_W'(1);
                    r_gcnt[r_open[GRP_W-1:0]] <= '0;
                    r_open                    <= r_open + OPEN_W'(1);
                end
            end
            if (i_cmd.place && (r_op == hpgt_pkg::OP_BUMP) && (OPEN_W'(r_sel) < r_open)) begin
                r_gcnt[r_sel] <= bump_inc;
            end
            if (i_cmd.sh_end && (r_op == hpgt_pkg::OP_REMOVE)) begin
                r_fill[r_g] <= fill_rd - FILL_W'(1);
            end
        end
    end

    // item sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_pend <= 1'b0;
        end else if (i_cmd.scan) begin
            r_pend <= scan_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_addr <= i_addr;
            r_init <= i_init;
            r_sel  <= i_sel;
            r_idx  <= '0;
            r_st   <= hpgt_pkg::ST_ABSENT;
            r_gi   <= '0;
            r_pc   <= '0;
            r_ev   <= 1'b0;
            r_ea   <= '0;
        end
        if (i_cmd.scan) begin
            r_pidx <= r_idx[SLOT_W-1:0];
            if (r_idx < (SLOT_W+1)'(SLOTS)) begin
                r_idx <= r_idx + 1'b1;
            end
            if (match) begin
                r_hidx <= r_pidx;
                r_hcnt <= r_rd_cnt;
            end
        end
        if (i_cmd.found) begin
            r_gi <= GRP_W'(r_hidx / PPG);
            r_g  <= GRP_W'(r_hidx / PPG);
            r_k  <= PG_W'(r_hidx % PPG);
            unique case (r_op)
                hpgt_pkg::OP_INSERT, hpgt_pkg::OP_UPDATE: begin
                    r_st <= hpgt_pkg::ST_HIT;
                    r_pc <= hit_inc;
                end
                hpgt_pkg::OP_REMOVE: begin
                    r_st <= hpgt_pkg::ST_REMOVED;
                    r_pc <= r_hcnt;
                end
                default: begin
                    r_st <= hpgt_pkg::ST_PRESENT;
                    r_pc <= r_hcnt;
                end
            endcase
        end
        if (i_cmd.place) begin
            if (is_ins) begin
                r_pc <= r_init;
                if (room_ok) begin
                    r_st <= hpgt_pkg::ST_ADD_OPEN;
                    r_gi <= g_room;
                end else if (can_open) begin
                    r_st <= hpgt_pkg::ST_ADD_NEW;
                    r_gi <= r_open[GRP_W-1:0];
                end else begin
                    r_st    <= hpgt_pkg::ST_REPLACED;
                    r_ev    <= 1'b1;
                    r_min_g <= '0;
                    r_minv  <= r_gcnt[0];
                    r_mk    <= OPEN_W'(1);
                end
            end else if (r_op == hpgt_pkg::OP_BUMP) begin
                r_gi <= r_sel;
                if (OPEN_W'(r_sel) < r_open) begin
                    r_st <= hpgt_pkg::ST_BUMPED;
                    r_pc <= bump_inc;
                end
            end
        end
        if (i_cmd.min_step) begin
            // strict compare keeps the first group on ties
            if (cnt_rd < r_minv) begin
                r_min_g <= r_mk[GRP_W-1:0];
                r_minv  <= cnt_rd;
            end
            r_mk <= r_mk + OPEN_W'(1);
        end
        if (i_cmd.ev_rd) begin
            r_g  <= r_min_g;
            r_gi <= r_min_g;
            r_k  <= '0;
        end
        if (i_cmd.ev_cap) begin
            r_ea <= r_rd_addr;
        end
        if (i_cmd.sh_wr) begin
            r_k <= r_k + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_st <= r_st;
            r_o_gi <= r_gi;
            r_o_pc <= r_pc;
            r_o_ev <= r_ev;
            r_o_ea <= r_ea;
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_status          = r_o_st;
    assign o_group_index     = r_o_gi;
    assign o_page_count      = r_o_pc;
    assign o_evicted_valid   = r_o_ev;
    assign o_evicted_address = r_o_ea;

    assign o_stat.hit         = match;
    assign o_stat.scan_end    = ((r_idx >= (SLOT_W+1)'(SLOTS)) && !r_pend)
                                || (r_op > hpgt_pkg::OP_LOOKUP);
    assign o_stat.is_remove   = (r_op == hpgt_pkg::OP_REMOVE);
    assign o_stat.need_min    = is_ins && !room_ok && !can_open;
    assign o_stat.min_more    = r_mk < r_open;
    assign o_stat.shift_more  = shift_more;
    assign o_stat.out_free    = !r_ovalid || i_out_ready;
    assign o_stat.groups_open = r_open;

endmodule

>>> rtl/hot_page_group_table_core.sv
// Hot-page group table: tracks up to 16 groups of 8 pages with saturating page and group
// counters. One item is worked at a time. A page operation searches the slot memory one
// entry per cycle through its single read port and stops early when the page is found;
// removal then moves the later pages of the group up, and an insert by replacement searches
// the open groups for the least group counter, evicts the oldest page of that group and
// shifts the group. A bump needs no search. The result is held in an output register, so a
// waiting result does not stop the next transfer in.
`include "assert_macros.svh"

module hot_page_group_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,   // max_groups
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,       // page_address, initial_count, group_select, zero pad
    input  logic [2:0]  s_tuser,       // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,       // group_index, page_count, evicted_address, zero pad
    output logic [3:0]  m_tuser        // status, evicted_valid
);

    hpgt_pkg::t_cmd  w_cmd;
    hpgt_pkg::t_stat w_stat;

    logic [hpgt_pkg::ST_W-1:0]   w_status;
    logic [hpgt_pkg::GRP_W-1:0]  w_gi;
    logic [hpgt_pkg::CNT_W-1:0]  w_pc;
    logic                        w_ev;
    logic [hpgt_pkg::ADDR_W-1:0] w_ea;

    hpgt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_ready (s_tready)
    );

    hpgt_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_op              (s_tuser),
        .i_addr            (s_tdata[47:0]),
        .i_init            (s_tdata[79:48]),
        .i_sel             (s_tdata[83:80]),
        .i_out_ready       (m_tready),
        .o_out_valid       (m_tvalid),
        .o_status          (w_status),
        .o_group_index     (w_gi),
        .o_page_count      (w_pc),
        .o_evicted_valid   (w_ev),
        .o_evicted_address (w_ea)
    );

    assign m_tdata = {4'b0000, w_ea, w_pc, w_gi};
    assign m_tuser = {w_ev, w_status};

    `HPGT_ASSERT(a_one_item, i_clk, i_rst_n, (s_tvalid && s_tready) |=> !s_tready)
    `HPGT_ASSERT(a_open_bound, i_clk, i_rst_n, w_stat.groups_open <= hpgt_pkg::GS)
    `HPGT_ASSERT(a_evict_status, i_clk, i_rst_n, (m_tvalid && m_tuser[3]) |-> (m_tuser[2:0] == hpgt_pkg::ST_REPLACED))

endmodule
